// File: rtl/lrm_pkg.sv
// ----------------------------------------------------------------------------
// lrm_pkg: shared types and constants of the longest regex match block
// Register map, node configuration record and the token control fields
// that travel along the row of node cells.
// ----------------------------------------------------------------------------
package lrm_pkg;

	// default sizes
	localparam int NODES_DEF    = 32;
	localparam int MAX_TEXT_DEF = 4096;
	localparam int POS_W_DEF    = 13;

	// payload widths
	localparam int CHAR_W  = 8;
	localparam int FIRST_W = 12;
	localparam int LEN_W   = 13;

	// register file
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_ADDR_W     = 6;
	localparam int REG_SHIFT      = 3;
	localparam int COUNT_W        = 6;
	localparam int REG_NODES      = 32;
	localparam int NODES_PER_REG  = CFG_DATA_W / CHAR_W;
	localparam int CHAR_REGS      = REG_NODES / NODES_PER_REG;

	typedef enum logic [CFG_ADDR_W-REG_SHIFT-1:0] {
		REG_NODE_COUNT = 3'd0,
		REG_CHARS_0    = 3'd1,
		REG_CHARS_1    = 3'd2,
		REG_CHARS_2    = 3'd3,
		REG_CHARS_3    = 3'd4,
		REG_SKIPPABLE  = 3'd5,
		REG_REPEATS    = 3'd6
	} cfg_reg_t;

	// input commands
	localparam logic [0:0] CMD_CHAR = 1'b0;
	localparam logic [0:0] CMD_EOS  = 1'b1;

	// per-cell copy of the pattern
	typedef struct packed {
		logic              in_use;
		logic              last;
		logic              skip;
		logic              rep;
		logic [CHAR_W-1:0] chr;
	} node_cfg_t;

	// control part of a token moving from cell to cell
	typedef struct packed {
		logic valid;
		logic eos;
		logic ovf;
		logic cin_on;
		logic nin_on;
		logic mt_on;
	} tok_ctl_t;

endpackage

// File: rtl/lrm_if.sv
// ----------------------------------------------------------------------------
// lrm_if: stream interfaces of the longest regex match block
// Text channel (characters and end of string) and match result channel.
// ----------------------------------------------------------------------------
interface lrm_text_if import lrm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [0:0]        command;
	logic [CHAR_W-1:0] ch;

	modport source (output valid, command, ch, input ready);
	modport sink (input valid, command, ch, output ready);
endinterface

interface lrm_match_if import lrm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic [FIRST_W-1:0] match_first;
	logic [LEN_W-1:0]   match_length;
	logic               too_long;

	modport source (output valid, found, match_first, match_length, too_long, input ready);
	modport sink (input valid, found, match_first, match_length, too_long, output ready);
endinterface

// File: rtl/lrm_cfg.sv
// ----------------------------------------------------------------------------
// lrm_cfg: pattern register file
// APB registers for the node chain and the decoded per-node settings.
// ----------------------------------------------------------------------------
module lrm_cfg import lrm_pkg::*; #(
	parameter int NODES = NODES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic                  wr,
	output node_cfg_t             cell_cfg [NODES]
);

	logic [COUNT_W-1:0]    count_q;
	logic [CFG_DATA_W-1:0] chars_q [CHAR_REGS];
	logic [REG_NODES-1:0]  skip_q;
	logic [REG_NODES-1:0]  rep_q;
	cfg_reg_t              idx;

	assign idx    = cfg_reg_t'(paddr[CFG_ADDR_W-1:REG_SHIFT]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < CHAR_REGS; i++) chars_q[i] <= '0;
			skip_q  <= '0;
			rep_q   <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_NODE_COUNT: count_q    <= pwdata[COUNT_W-1:0];
				REG_CHARS_0:    chars_q[0] <= pwdata;
				REG_CHARS_1:    chars_q[1] <= pwdata;
				REG_CHARS_2:    chars_q[2] <= pwdata;
				REG_CHARS_3:    chars_q[3] <= pwdata;
				REG_SKIPPABLE:  skip_q     <= pwdata[REG_NODES-1:0];
				REG_REPEATS:    rep_q      <= pwdata[REG_NODES-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_NODE_COUNT: prdata = CFG_DATA_W'(count_q);
			REG_CHARS_0:    prdata = chars_q[0];
			REG_CHARS_1:    prdata = chars_q[1];
			REG_CHARS_2:    prdata = chars_q[2];
			REG_CHARS_3:    prdata = chars_q[3];
			REG_SKIPPABLE:  prdata = CFG_DATA_W'(skip_q);
			REG_REPEATS:    prdata = CFG_DATA_W'(rep_q);
			default:        prdata = '0;
		endcase
	end

	for (genvar k = 0; k < NODES; k++) begin : g_node
		// end of chain sits on the last node in use, capped at the row length
		assign cell_cfg[k].in_use = (k < int'(count_q));
		assign cell_cfg[k].last   = (k < int'(count_q)) &&
			((k + 1 >= int'(count_q)) || (k == NODES - 1));
		if (k < REG_NODES) begin : g_reg
			assign cell_cfg[k].chr  =
				chars_q[k / NODES_PER_REG][(k % NODES_PER_REG) * CHAR_W +: CHAR_W];
			assign cell_cfg[k].skip = skip_q[k] | rep_q[k];
			assign cell_cfg[k].rep  = rep_q[k];
		end else begin : g_none
			assign cell_cfg[k].chr  = '0;
			assign cell_cfg[k].skip = 1'b0;
			assign cell_cfg[k].rep  = 1'b0;
		end
	end

endmodule

// File: rtl/lrm_cell.sv
// ----------------------------------------------------------------------------
// lrm_cell: one pattern node of the chain
// Holds the earliest start waiting on its node, forms both skip closures and
// the character step for one token and hands the token on to the next node.
// ----------------------------------------------------------------------------
module lrm_cell import lrm_pkg::*; #(
	parameter int PW = POS_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              ld,
	input  node_cfg_t         cfg_new,
	input  tok_ctl_t          ctl_i,
	input  logic [CHAR_W-1:0] ch_i,
	input  logic [PW-1:0]     p_i,
	input  logic [PW-1:0]     cst_i,
	input  logic [PW-1:0]     nst_i,
	input  logic [PW-1:0]     mst_i,
	output tok_ctl_t          ctl_o,
	output logic [CHAR_W-1:0] ch_o,
	output logic [PW-1:0]     p_o,
	output logic [PW-1:0]     cst_o,
	output logic [PW-1:0]     nst_o,
	output logic [PW-1:0]     mst_o
);

	node_cfg_t         cfg_q;
	logic              armed_q;
	logic [PW-1:0]     st_q;
	tok_ctl_t          ctl_q;
	logic [CHAR_W-1:0] ch_q;
	logic [PW-1:0]     p_q;
	logic [PW-1:0]     cst_q;
	logic [PW-1:0]     nst_q;
	logic [PW-1:0]     mst_q;

	logic          act;
	logic          own_on;
	logic          cur_on;
	logic [PW-1:0] cur_st;
	logic          hit;
	logic          self_hit;
	logic          fwd_hit;
	logic          nxt_on;
	logic [PW-1:0] nxt_st;
	logic          skip_on;
	logic          nout_on;
	logic [PW-1:0] nout_st;
	logic          end_hit;

	always_comb begin
		act    = ctl_i.valid & ~ctl_i.eos & cfg_q.in_use;
		own_on = armed_q & cfg_q.in_use;

		// threads waiting here merged with the skip closure from the left
		cur_on = act & (own_on | ctl_i.cin_on);
		if (own_on && ctl_i.cin_on) begin
			cur_st = (st_q < cst_i) ? st_q : cst_i;
		end else if (own_on) begin
			cur_st = st_q;
		end else begin
			cur_st = cst_i;
		end

		hit      = cur_on & (ch_i == cfg_q.chr);
		self_hit = hit & cfg_q.rep;
		fwd_hit  = hit & ~cfg_q.rep;

		// state after the character, including closure from the left
		nxt_on = (act & ctl_i.nin_on) | self_hit;
		if (ctl_i.nin_on && self_hit) begin
			nxt_st = (nst_i < cur_st) ? nst_i : cur_st;
		end else if (ctl_i.nin_on) begin
			nxt_st = nst_i;
		end else begin
			nxt_st = cur_st;
		end

		skip_on = nxt_on & cfg_q.skip;
		nout_on = fwd_hit | skip_on;
		if (fwd_hit && skip_on) begin
			nout_st = (cur_st < nxt_st) ? cur_st : nxt_st;
		end else if (fwd_hit) begin
			nout_st = cur_st;
		end else begin
			nout_st = nxt_st;
		end

		end_hit = act & cfg_q.last & nout_on;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= '0;
			armed_q <= 1'b0;
			ctl_q   <= '0;
		end else if (en) begin
			if (ld) cfg_q <= cfg_new;
			// end of string clears the node as it passes
			if (ctl_i.valid) armed_q <= nxt_on;
			ctl_q.valid  <= ctl_i.valid;
			ctl_q.eos    <= ctl_i.eos;
			ctl_q.ovf    <= ctl_i.ovf;
			ctl_q.cin_on <= cur_on & cfg_q.skip;
			ctl_q.nin_on <= nout_on;
			ctl_q.mt_on  <= end_hit | ctl_i.mt_on;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_i.valid) st_q <= nxt_st;
			ch_q  <= ch_i;
			p_q   <= p_i;
			cst_q <= cur_st;
			nst_q <= nout_st;
			mst_q <= end_hit ? nout_st : mst_i;
		end
	end

	assign ctl_o = ctl_q;
	assign ch_o  = ch_q;
	assign p_o   = p_q;
	assign cst_o = cst_q;
	assign nst_o = nst_q;
	assign mst_o = mst_q;

endmodule

// File: rtl/lrm_result.sv
// ----------------------------------------------------------------------------
// lrm_result: best match tracking and result register
// Keeps the longest match seen at the end of the chain and presents it on
// the result channel when the end of string arrives.
// ----------------------------------------------------------------------------
module lrm_result import lrm_pkg::*; #(
	parameter int PW = POS_W_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tok_ctl_t      ctl_i,
	input  logic [PW-1:0] p_i,
	input  logic [PW-1:0] mst_i,
	output logic          en,
	lrm_match_if.source   result
);

	logic          best_found_q;
	logic [PW-1:0] best_first_q;
	logic [PW-1:0] best_len_q;
	logic          out_valid_q;
	logic          found_q;
	logic [PW-1:0] first_q;
	logic [PW-1:0] len_q;
	logic          too_long_q;
	logic [PW-1:0] len;
	logic          update;
	logic          eos_in;

	assign len    = p_i - mst_i + PW'(1);
	assign eos_in = ctl_i.valid & ctl_i.eos;
	assign update = ctl_i.valid & ~ctl_i.eos & ctl_i.mt_on & (len >= best_len_q);
	// whole chain holds while a second result would overwrite an untaken one
	assign en     = ~(eos_in & out_valid_q & ~result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
			best_first_q <= '0;
			best_len_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (en && eos_in) begin
				best_found_q <= 1'b0;
				best_first_q <= '0;
				best_len_q   <= '0;
			end else if (en && update) begin
				best_found_q <= 1'b1;
				best_first_q <= mst_i;
				best_len_q   <= len;
			end
			if (en && eos_in) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && eos_in) begin
			found_q    <= best_found_q;
			first_q    <= best_first_q;
			len_q      <= best_len_q;
			too_long_q <= ctl_i.ovf;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = found_q;
	assign result.match_first  = FIRST_W'(first_q);
	assign result.match_length = LEN_W'(len_q);
	assign result.too_long     = too_long_q;

endmodule

// File: rtl/longest_regex_match.sv
// ----------------------------------------------------------------------------
// longest_regex_match: longest match of a chain pattern over a text stream
// Top level: input stage, row of node cells, result stage, register file.
// ----------------------------------------------------------------------------
// The pattern (node count, node characters, skip and repeat flags) is written
// through the APB port; pready is always high and reads return the registers.
// The text channel carries one character per transfer (command 0) or an end
// of string (command 1). Every character and end of string travels down a
// row of NODES node cells, one cell per cycle, so a new transfer is taken
// every cycle while the row is not stalled.
// An end of string passes the input stage, the row and the result register
// and yields one result transfer: found, first index, length, too_long flag.
// Characters beyond MAX_TEXT in one string are dropped and set too_long.
// A pattern update reaches each cell together with the first character
// taken after it, so write it between transfers.
// The result register frees the row while a result waits; a second end of
// string reaching the end of the row with the first result still untaken
// stalls the row and drops text ready.
// Reset clears the pattern, the armed flags and tokens of the nodes and the match record.
// ----------------------------------------------------------------------------
module longest_regex_match import lrm_pkg::*; #(
	parameter int NODES    = NODES_DEF,
	parameter int MAX_TEXT = MAX_TEXT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lrm_text_if.sink              text,
	lrm_match_if.source           result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int PW = $clog2(MAX_TEXT + 1);

	logic          en;
	logic          cfg_wr;
	node_cfg_t     cell_cfg [NODES];
	logic          ld_q [NODES];

	tok_ctl_t          ctl0_d;
	tok_ctl_t          ctl0_q;
	logic [CHAR_W-1:0] ch0_q;
	logic [PW-1:0]     p0_q;
	logic [PW-1:0]     pos_q;
	logic              ovf_q;

	tok_ctl_t          ctl  [NODES+1];
	logic [CHAR_W-1:0] chs  [NODES+1];
	logic [PW-1:0]     ps   [NODES+1];
	logic [PW-1:0]     csts [NODES+1];
	logic [PW-1:0]     nsts [NODES+1];
	logic [PW-1:0]     msts [NODES+1];

	lrm_cfg #(.NODES(NODES)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.wr       (cfg_wr),
		.cell_cfg (cell_cfg)
	);

	// input stage: position counter, overflow flag and the token for cell 0
	assign text.ready = en;

	always_comb begin
		ctl0_d = '0;
		if (text.valid) begin
			if (text.command == CMD_EOS) begin
				ctl0_d.valid = 1'b1;
				ctl0_d.eos   = 1'b1;
				ctl0_d.ovf   = ovf_q;
			end else if (pos_q < PW'(MAX_TEXT)) begin
				ctl0_d.valid  = 1'b1;
				ctl0_d.cin_on = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl0_q <= '0;
			pos_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (en) begin
			ctl0_q <= ctl0_d;
			if (text.valid) begin
				if (text.command == CMD_EOS) begin
					pos_q <= '0;
					ovf_q <= 1'b0;
				end else if (pos_q < PW'(MAX_TEXT)) begin
					pos_q <= pos_q + PW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch0_q <= text.ch;
			p0_q  <= pos_q;
		end
	end

	// pattern load marker runs down the row in step with the tokens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q[0] <= 1'b0;
		end else if (cfg_wr) begin
			ld_q[0] <= 1'b1;
		end else if (en) begin
			ld_q[0] <= 1'b0;
		end
	end

	for (genvar k = 1; k < NODES; k++) begin : g_ld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ld_q[k] <= 1'b0;
			end else if (en) begin
				ld_q[k] <= ld_q[k-1];
			end
		end
	end

	// a fresh thread at node 0 starts at the current position
	assign ctl[0]  = ctl0_q;
	assign chs[0]  = ch0_q;
	assign ps[0]   = p0_q;
	assign csts[0] = p0_q;
	assign nsts[0] = '0;
	assign msts[0] = '0;

	for (genvar k = 0; k < NODES; k++) begin : g_cell
		lrm_cell #(.PW(PW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ld      (ld_q[k]),
			.cfg_new (cell_cfg[k]),
			.ctl_i   (ctl[k]),
			.ch_i    (chs[k]),
			.p_i     (ps[k]),
			.cst_i   (csts[k]),
			.nst_i   (nsts[k]),
			.mst_i   (msts[k]),
			.ctl_o   (ctl[k+1]),
			.ch_o    (chs[k+1]),
			.p_o     (ps[k+1]),
			.cst_o   (csts[k+1]),
			.nst_o   (nsts[k+1]),
			.mst_o   (msts[k+1])
		);
	end

	lrm_result #(.PW(PW)) u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl[NODES]),
		.p_i    (ps[NODES]),
		.mst_i  (msts[NODES]),
		.en     (en),
		.result (result)
	);

endmodule
